// ===== hdl/frm_pkg.sv =====
// frm_pkg: shared types and constants for the frame rate monitor
// used by frm_divider and frame_rate_monitor
package frm_pkg;

    localparam int HistLen  = 16;
    localparam int HistIdxW = $clog2(HistLen);
    localparam int HistCntW = $clog2(HistLen + 1);
    localparam int DivW     = 64;
    localparam int DivCntW  = $clog2(DivW + 1);

    localparam logic [15:0] WindowReset = 16'd1000;
    localparam logic [23:0] Sat24 = 24'hFFFFFF;
    localparam logic [15:0] Sat16 = 16'hFFFF;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FEEL_SUM,
        ST_FEEL_DIV,
        ST_TICK_SUM,
        ST_TICK_DIV,
        ST_MSPT_DIV,
        ST_SHIFT,
        ST_OUT
    } t_state;

    // operands handed to the shared divider
    typedef struct packed {
        logic            start;
        logic [DivW-1:0] num;
        logic [DivW-1:0] den;
    } t_div_req;

endpackage

// ===== hdl/frm_divider.sv =====
// frm_divider: bit-serial restoring divider, one quotient bit per cycle
// depends on frm_pkg
module frm_divider (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  frm_pkg::t_div_req        i_req,
    output logic                     o_done,
    output logic [frm_pkg::DivW-1:0] o_quot
);
    logic [frm_pkg::DivW-1:0]    r_rem, n_rem;
    logic [frm_pkg::DivW-1:0]    r_quot, n_quot;
    logic [frm_pkg::DivW-1:0]    r_den, n_den;
    logic [frm_pkg::DivCntW-1:0] r_cnt, n_cnt;
    logic                        r_busy, n_busy;
    logic                        r_done, n_done;
    logic [frm_pkg::DivW:0]      w_trial;

    always_comb begin
        n_rem  = r_rem;
        n_quot = r_quot;
        n_den  = r_den;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        w_trial = {r_rem, r_quot[frm_pkg::DivW-1]} - {1'b0, r_den};
        if (i_req.start) begin
            n_rem  = '0;
            n_quot = i_req.num;
            n_den  = i_req.den;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            // shift one numerator bit into the remainder and try a subtract
            if (!w_trial[frm_pkg::DivW]) begin
                n_rem = w_trial[frm_pkg::DivW-1:0];
                n_quot = {r_quot[frm_pkg::DivW-2:0], 1'b1};
            end else begin
                n_rem = {r_rem[frm_pkg::DivW-2:0], r_quot[frm_pkg::DivW-1]};
                n_quot = {r_quot[frm_pkg::DivW-2:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == frm_pkg::DivCntW'(frm_pkg::DivW - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem  <= n_rem;
        r_quot <= n_quot;
        r_den  <= n_den;
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule

// ===== hdl/frame_rate_monitor.sv =====
// frame_rate_monitor: windowed frame rate meter, top level
// depends on frm_pkg and frm_divider
//
// Usage: items arrive on the i_valid/o_ready channel. A tick item (req_type
// 0) only bumps the tick counter and gives no result; the block stays idle.
// A frame item (req_type 1) gives exactly one result on o_valid/i_ready.
// The block works on one item at a time: o_ready is high only while idle.
// A frame that does not close a window runs the ms-per-tick division;
// one that closes a window also runs the history sums over all 16 entries
// and two more divisions. Every division goes through one shared
// bit-serial divider, and the history lines are shifted one entry per cycle.
// The result sits in an output register until it is taken; while the
// receiver stalls no new item is accepted.
// window_ms is written over the APB port at address 0 and read back there.
// Reset clears the frame and tick counters, the latched fps, feels-like and
// tick rates and both histories (not ms_per_tick) and sets window_ms to 1000.
module frame_rate_monitor (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_req_type,
    input  logic [31:0] i_now_ms,
    input  logic [15:0] i_frame_ms,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_window_closed,
    output logic [15:0] o_frames_per_sec,
    output logic [23:0] o_feels_like_fps,
    output logic [23:0] o_ticks_per_sec,
    output logic [23:0] o_ms_per_tick,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int IW = frm_pkg::HistIdxW;
    localparam int CW = frm_pkg::HistCntW;

    frm_pkg::t_state r_state, n_state;

    logic [15:0] r_window_ms;
    logic [31:0] r_window_start, n_window_start;
    logic [15:0] r_frame_cnt, n_frame_cnt;
    logic [15:0] r_tick_cnt, n_tick_cnt;
    logic [15:0] r_lat_fps, n_lat_fps;
    logic [23:0] r_lat_feel, n_lat_feel;
    logic [23:0] r_lat_tps, n_lat_tps;
    logic [15:0] r_fhist [frm_pkg::HistLen];
    logic [15:0] r_thist [frm_pkg::HistLen];
    logic [15:0] r_dur, n_dur;
    logic        r_closed, n_closed;
    logic [IW-1:0] r_idx, n_idx;
    logic [23:0] r_s1, n_s1;
    logic [39:0] r_s2, n_s2;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [23:0] r_mspt, n_mspt;
    logic        r_ovalid, n_ovalid;
    logic        r_divgo, n_divgo;
    logic        w_fshift, w_tshift, w_tpush;
    logic [15:0] w_fhead, w_thead;
    logic [31:0] w_sq;

    frm_pkg::t_div_req w_req;
    logic              w_div_done;
    logic [63:0]       w_quot;
    logic [23:0]       w_quot_sat;

    frm_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    assign w_quot_sat = (w_quot > 64'(frm_pkg::Sat24)) ? frm_pkg::Sat24 : w_quot[23:0];
    assign w_fhead = r_fhist[0];
    assign w_thead = r_thist[0];
    assign w_sq = w_fhead * w_fhead;

    // apb
    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? {16'd0, r_window_ms} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_ms <= frm_pkg::WindowReset;
        end else if (psel && penable && pwrite && paddr == 2'd0) begin
            r_window_ms <= pwdata[15:0];
        end
    end

    assign o_ready = (r_state == frm_pkg::ST_IDLE);

    always_comb begin
        n_state = r_state;
        n_window_start = r_window_start;
        n_frame_cnt = r_frame_cnt;
        n_tick_cnt = r_tick_cnt;
        n_lat_fps = r_lat_fps;
        n_lat_feel = r_lat_feel;
        n_lat_tps = r_lat_tps;
        n_dur = r_dur;
        n_closed = r_closed;
        n_idx = r_idx;
        n_s1 = r_s1;
        n_s2 = r_s2;
        n_cnt = r_cnt;
        n_mspt = r_mspt;
        n_ovalid = r_ovalid;
        n_divgo = 1'b0;
        w_fshift = 1'b0;
        w_tshift = 1'b0;
        w_tpush = 1'b0;
        w_req.start = r_divgo;
        w_req.num = '0;
        w_req.den = '0;
        unique case (r_state)
            frm_pkg::ST_IDLE: begin
                if (i_valid) begin
                    if (!i_req_type) begin
                        if (r_tick_cnt != frm_pkg::Sat16) n_tick_cnt = r_tick_cnt + 1'b1;
                    end else begin
                        n_dur = i_frame_ms;
                        n_idx = '0;
                        n_s1 = '0;
                        n_s2 = '0;
                        n_cnt = '0;
                        if (i_now_ms - r_window_start >= {16'd0, r_window_ms}) begin
                            n_closed = 1'b1;
                            n_window_start = i_now_ms;
                            n_lat_fps = (r_frame_cnt != frm_pkg::Sat16) ?
                                        r_frame_cnt + 1'b1 : r_frame_cnt;
                            n_frame_cnt = '0;
                            n_state = frm_pkg::ST_FEEL_SUM;
                        end else begin
                            n_closed = 1'b0;
                            if (r_frame_cnt != frm_pkg::Sat16)
                                n_frame_cnt = r_frame_cnt + 1'b1;
                            n_divgo = 1'b1;
                            n_state = frm_pkg::ST_MSPT_DIV;
                        end
                    end
                end
            end
            frm_pkg::ST_FEEL_SUM: begin
                // rotate the frame line once around, one entry a cycle
                n_s1 = r_s1 + 24'(w_fhead);
                n_s2 = r_s2 + 40'(w_sq);
                w_fshift = 1'b1;
                n_idx = r_idx + 1'b1;
                if (r_idx == IW'(frm_pkg::HistLen - 1)) begin
                    n_divgo = 1'b1;
                    n_state = frm_pkg::ST_FEEL_DIV;
                end
            end
            frm_pkg::ST_FEEL_DIV: begin
                w_req.num = (64'(r_s1) * 64'd100 + 64'd1) * 64'd256000;
                w_req.den = 64'(r_s2) * 64'd100;
                if (w_div_done) begin
                    n_lat_feel = (r_s2 == '0) ? frm_pkg::Sat24 : w_quot_sat;
                    n_s1 = '0;
                    n_idx = '0;
                    w_tpush = 1'b1;
                    n_state = frm_pkg::ST_TICK_SUM;
                end
            end
            frm_pkg::ST_TICK_SUM: begin
                if (w_thead != '0) begin
                    n_s1 = r_s1 + 24'(w_thead);
                    n_cnt = r_cnt + 1'b1;
                end
                w_tshift = 1'b1;
                n_idx = r_idx + 1'b1;
                if (r_idx == IW'(frm_pkg::HistLen - 1)) begin
                    n_divgo = 1'b1;
                    n_state = frm_pkg::ST_TICK_DIV;
                end
            end
            frm_pkg::ST_TICK_DIV: begin
                w_req.num = 64'({r_s1, 8'd0});
                w_req.den = 64'(r_cnt);
                if (w_div_done) begin
                    n_lat_tps = (r_cnt == '0) ? 24'd0 : w_quot_sat;
                    n_tick_cnt = '0;
                    n_divgo = 1'b1;
                    n_state = frm_pkg::ST_MSPT_DIV;
                end
            end
            frm_pkg::ST_MSPT_DIV: begin
                w_req.num = 64'd65536000;
                w_req.den = 64'(r_lat_tps);
                if (w_div_done) begin
                    n_mspt = (r_lat_tps == '0) ? frm_pkg::Sat24 : w_quot_sat;
                    n_state = frm_pkg::ST_SHIFT;
                end
            end
            frm_pkg::ST_SHIFT: begin
                n_ovalid = 1'b1;
                n_state = frm_pkg::ST_OUT;
            end
            frm_pkg::ST_OUT: begin
                if (i_ready) begin
                    n_ovalid = 1'b0;
                    n_state = frm_pkg::ST_IDLE;
                end
            end
            default: n_state = frm_pkg::ST_IDLE;
        endcase
    end

    // history lines: rotate during sums, push at entry 15 in ST_SHIFT (frame) or on w_tpush (tick)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < frm_pkg::HistLen; i++) begin
                r_fhist[i] <= '0;
                r_thist[i] <= '0;
            end
        end else begin
            if (w_fshift) begin
                for (int i = 0; i < frm_pkg::HistLen - 1; i++) r_fhist[i] <= r_fhist[i+1];
                r_fhist[frm_pkg::HistLen-1] <= r_fhist[0];
            end else if (r_state == frm_pkg::ST_SHIFT) begin
                for (int i = 0; i < frm_pkg::HistLen - 1; i++) r_fhist[i] <= r_fhist[i+1];
                r_fhist[frm_pkg::HistLen-1] <= r_dur;
            end
            if (w_tshift) begin
                for (int i = 0; i < frm_pkg::HistLen - 1; i++) r_thist[i] <= r_thist[i+1];
                r_thist[frm_pkg::HistLen-1] <= r_thist[0];
            end else if (w_tpush) begin
                for (int i = 0; i < frm_pkg::HistLen - 1; i++) r_thist[i] <= r_thist[i+1];
                r_thist[frm_pkg::HistLen-1] <= r_tick_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= frm_pkg::ST_IDLE;
            r_window_start <= '0;
            r_frame_cnt <= '0;
            r_tick_cnt <= '0;
            r_lat_fps <= '0;
            r_lat_feel <= '0;
            r_lat_tps <= '0;
            r_ovalid <= 1'b0;
            r_divgo <= 1'b0;
            r_idx <= '0;
        end else begin
            r_state <= n_state;
            r_window_start <= n_window_start;
            r_frame_cnt <= n_frame_cnt;
            r_tick_cnt <= n_tick_cnt;
            r_lat_fps <= n_lat_fps;
            r_lat_feel <= n_lat_feel;
            r_lat_tps <= n_lat_tps;
            r_ovalid <= n_ovalid;
            r_divgo <= n_divgo;
            r_idx <= n_idx;
        end
        r_dur <= n_dur;
        r_closed <= n_closed;
        r_s1 <= n_s1;
        r_s2 <= n_s2;
        r_cnt <= n_cnt;
        r_mspt <= n_mspt;
    end

    assign o_valid = r_ovalid;
    assign o_window_closed = r_closed;
    assign o_frames_per_sec = r_lat_fps;
    assign o_feels_like_fps = r_lat_feel;
    assign o_ticks_per_sec = r_lat_tps;
    assign o_ms_per_tick = r_mspt;
endmodule
